FILE: design/msct_pkg.sv
// Shared types, constants and case tables for the marching-squares cell triangulator.
// No dependencies; every other design file refers to this package by scoped names.
package msct_pkg;

  // Field widths
  localparam int COORD_W   = 8;
  localparam int DENS_W    = 9;
  localparam int VTX_W     = 18;
  localparam int SLOT_W    = 2;
  localparam int COUNT_W   = 3;
  localparam int CODE_W    = 4;
  localparam int FRAC_W    = 8;
  localparam int NUM_SLOTS = 4;

  // Grid size defaults
  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;

  // Threshold after reset (0.5 in Q1.8)
  localparam logic [DENS_W-1:0] THRESHOLD_RESET = 9'd128;

  // Crossing fraction clamp limits, 0.1 and 0.9 in Q0.8
  localparam logic [FRAC_W-1:0] FRAC_LOW  = 8'd26;
  localparam logic [FRAC_W-1:0] FRAC_HIGH = 8'd230;

  // Case code corner bits
  localparam logic [CODE_W-1:0] CORNER_TL_BIT = 4'b0001;
  localparam logic [CODE_W-1:0] CORNER_TR_BIT = 4'b0010;
  localparam logic [CODE_W-1:0] CORNER_BR_BIT = 4'b0100;
  localparam logic [CODE_W-1:0] CORNER_BL_BIT = 4'b1000;

  // Last slot of a cell
  localparam logic [SLOT_W-1:0] LAST_SLOT = 2'(NUM_SLOTS - 1);

  // Cell queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Symbolic cell vertices: four corners, then top, bottom, left, right edges
  typedef enum logic [2:0] {
    VS_TL     = 3'd0,
    VS_TR     = 3'd1,
    VS_BR     = 3'd2,
    VS_BL     = 3'd3,
    VS_TOP    = 3'd4,
    VS_BOTTOM = 3'd5,
    VS_LEFT   = 3'd6,
    VS_RIGHT  = 3'd7
  } vtx_sel_e;

  typedef struct packed {
    vtx_sel_e a;
    vtx_sel_e b;
    vtx_sel_e c;
  } tri_t;

  typedef tri_t [NUM_SLOTS-1:0] tri_row_t;

  // Classified cell handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [VTX_W-1:0]   y_w;      // y * W
    logic [VTX_W-1:0]   y_w1;     // y * (W - 1)
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
    logic [FRAC_W-1:0]  top;
    logic [FRAC_W-1:0]  left;
  } cell_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic tri_t mk_tri(vtx_sel_e a, vtx_sel_e b, vtx_sel_e c);
    tri_t t;
    t.a = a;
    t.b = b;
    t.c = c;
    return t;
  endfunction

  // Triangle table, slot 0 in the low position; unused slots are zero
  function automatic tri_row_t tri_lookup(logic [CODE_W-1:0] code);
    tri_row_t row;
    row = '0;
    case (code)
      4'd0:  row = '0;
      4'd1:  row[0] = mk_tri(VS_TL, VS_TOP, VS_LEFT);
      4'd2:  row[0] = mk_tri(VS_RIGHT, VS_TR, VS_TOP);
      4'd3: begin
        row[0] = mk_tri(VS_TR, VS_LEFT, VS_TL);
        row[1] = mk_tri(VS_TR, VS_RIGHT, VS_LEFT);
      end
      4'd4:  row[0] = mk_tri(VS_BR, VS_BOTTOM, VS_RIGHT);
      4'd5: begin
        row[0] = mk_tri(VS_TL, VS_TOP, VS_LEFT);
        row[1] = mk_tri(VS_BR, VS_BOTTOM, VS_RIGHT);
        row[2] = mk_tri(VS_TOP, VS_BOTTOM, VS_LEFT);
        row[3] = mk_tri(VS_TOP, VS_RIGHT, VS_BOTTOM);
      end
      4'd6: begin
        row[0] = mk_tri(VS_BR, VS_TOP, VS_TR);
        row[1] = mk_tri(VS_BR, VS_BOTTOM, VS_TOP);
      end
      4'd7: begin
        row[0] = mk_tri(VS_TL, VS_TR, VS_LEFT);
        row[1] = mk_tri(VS_TR, VS_BOTTOM, VS_LEFT);
        row[2] = mk_tri(VS_TR, VS_BR, VS_BOTTOM);
      end
      4'd8:  row[0] = mk_tri(VS_BL, VS_LEFT, VS_BOTTOM);
      4'd9: begin
        row[0] = mk_tri(VS_TL, VS_BOTTOM, VS_BL);
        row[1] = mk_tri(VS_TL, VS_TOP, VS_BOTTOM);
      end
      4'd10: begin
        row[0] = mk_tri(VS_TR, VS_RIGHT, VS_TOP);
        row[1] = mk_tri(VS_BL, VS_LEFT, VS_BOTTOM);
        row[2] = mk_tri(VS_TOP, VS_RIGHT, VS_LEFT);
        row[3] = mk_tri(VS_RIGHT, VS_BOTTOM, VS_LEFT);
      end
      4'd11: begin
        row[0] = mk_tri(VS_BL, VS_TL, VS_BOTTOM);
        row[1] = mk_tri(VS_TL, VS_RIGHT, VS_BOTTOM);
        row[2] = mk_tri(VS_TL, VS_TR, VS_RIGHT);
      end
      4'd12: begin
        row[0] = mk_tri(VS_BL, VS_RIGHT, VS_BR);
        row[1] = mk_tri(VS_BL, VS_LEFT, VS_RIGHT);
      end
      4'd13: begin
        row[0] = mk_tri(VS_BR, VS_BL, VS_RIGHT);
        row[1] = mk_tri(VS_BL, VS_TOP, VS_RIGHT);
        row[2] = mk_tri(VS_BL, VS_TL, VS_TOP);
      end
      4'd14: begin
        row[0] = mk_tri(VS_TR, VS_BR, VS_TOP);
        row[1] = mk_tri(VS_BR, VS_LEFT, VS_TOP);
        row[2] = mk_tri(VS_BR, VS_BL, VS_LEFT);
      end
      4'd15: begin
        row[0] = mk_tri(VS_TL, VS_TR, VS_BR);
        row[1] = mk_tri(VS_BR, VS_BL, VS_TL);
      end
      default: row = '0;
    endcase
    return row;
  endfunction

  // Number of real triangles per case
  function automatic logic [COUNT_W-1:0] tri_count(logic [CODE_W-1:0] code);
    logic [COUNT_W-1:0] n;
    case (code)
      4'd0:              n = 3'd0;
      4'd1, 4'd2, 4'd4,
      4'd8:              n = 3'd1;
      4'd3, 4'd6, 4'd9,
      4'd12, 4'd15:      n = 3'd2;
      4'd7, 4'd11, 4'd13,
      4'd14:             n = 3'd3;
      4'd5, 4'd10:       n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: design/msct_queue.sv
// Two-entry cell queue between the classifier front and the slot emitter back.
// Depends on msct_pkg for the cell record and status struct.
module msct_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  msct_pkg::cell_t    push_data_i,
  input  logic               pop_i,
  output msct_pkg::cell_t    head_o,
  output msct_pkg::q_status_t status_o
);

  msct_pkg::cell_t                    mem_q [msct_pkg::QUEUE_DEPTH];
  logic [msct_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [msct_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [msct_pkg::QCNT_W-1:0]        cnt_q, cnt_d;
  logic                               do_push, do_pop;

  localparam logic [msct_pkg::QPTR_W-1:0] PTR_LAST = msct_pkg::QPTR_W'(msct_pkg::QUEUE_DEPTH - 1);
  localparam logic [msct_pkg::QCNT_W-1:0] CNT_FULL = msct_pkg::QCNT_W'(msct_pkg::QUEUE_DEPTH);

  assign status_o.full  = (cnt_q == CNT_FULL);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/msct_front.sv
// Front end: threshold register, request intake, case code, edge fractions, row products.
// Depends on msct_pkg; pushes one classified cell into msct_queue.
module msct_front #(
  parameter int GRID_WIDTH = msct_pkg::GRID_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                threshold_we_i,
  input  logic [msct_pkg::DENS_W-1:0]         threshold_i,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [msct_pkg::COORD_W-1:0]        cell_x_i,
  input  logic [msct_pkg::COORD_W-1:0]        cell_y_i,
  input  logic [msct_pkg::DENS_W-1:0]         corner_top_left_i,
  input  logic [msct_pkg::DENS_W-1:0]         corner_top_right_i,
  input  logic [msct_pkg::DENS_W-1:0]         corner_bottom_right_i,
  input  logic [msct_pkg::DENS_W-1:0]         corner_bottom_left_i,
  input  msct_pkg::q_status_t                 q_status_i,
  output logic                                push_o,
  output msct_pkg::cell_t                     cell_o
);

  localparam logic [msct_pkg::VTX_W-1:0] W_V  = msct_pkg::VTX_W'(GRID_WIDTH);
  localparam logic [msct_pkg::VTX_W-1:0] W1_V = msct_pkg::VTX_W'(GRID_WIDTH - 1);

  logic [msct_pkg::DENS_W-1:0] threshold_q;
  logic                        fr_valid_q, fr_valid_d;
  msct_pkg::cell_t             fr_cell_q, fr_cell_d;
  logic                        accept;
  logic [msct_pkg::VTX_W-1:0]  y_ext;

  // Clamped crossing fraction of one edge, in 1/256 units
  function automatic logic [msct_pkg::FRAC_W-1:0] edge_fraction(
    logic [msct_pkg::DENS_W-1:0] g1,
    logic [msct_pkg::DENS_W-1:0] g2,
    logic [msct_pkg::DENS_W-1:0] th
  );
    logic signed [11:0] s1, s2, sth, t;
    s1  = signed'({3'b000, g1});
    s2  = signed'({3'b000, g2});
    sth = signed'({3'b000, th});
    if (g1 > g2) begin
      t = s1 + s2 - sth;
    end else begin
      t = 12'sd256 - s1 - s2 + sth;
    end
    if (t < signed'({4'b0000, msct_pkg::FRAC_LOW})) begin
      return msct_pkg::FRAC_LOW;
    end else if (t > signed'({4'b0000, msct_pkg::FRAC_HIGH})) begin
      return msct_pkg::FRAC_HIGH;
    end
    return t[msct_pkg::FRAC_W-1:0];
  endfunction

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= msct_pkg::THRESHOLD_RESET;
    end else if (threshold_we_i) begin
      threshold_q <= threshold_i;
    end
  end

  // Handshake: hold the stage while the queue is full
  assign stall_o = fr_valid_q && q_status_i.full;
  assign accept  = valid_i && !stall_o;
  assign push_o  = fr_valid_q && !q_status_i.full;
  assign cell_o  = fr_cell_q;
  assign y_ext   = {{(msct_pkg::VTX_W - msct_pkg::COORD_W){1'b0}}, cell_y_i};

  // Classification of the incoming cell
  always_comb begin
    fr_cell_d.x    = cell_x_i;
    fr_cell_d.y_w  = y_ext * W_V;
    fr_cell_d.y_w1 = y_ext * W1_V;
    fr_cell_d.code = ((corner_top_left_i     > threshold_q) ? msct_pkg::CORNER_TL_BIT : '0)
                   | ((corner_top_right_i    > threshold_q) ? msct_pkg::CORNER_TR_BIT : '0)
                   | ((corner_bottom_right_i > threshold_q) ? msct_pkg::CORNER_BR_BIT : '0)
                   | ((corner_bottom_left_i  > threshold_q) ? msct_pkg::CORNER_BL_BIT : '0);
    fr_cell_d.count = msct_pkg::tri_count(fr_cell_d.code);
    fr_cell_d.top   = edge_fraction(corner_top_left_i, corner_top_right_i, threshold_q);
    fr_cell_d.left  = edge_fraction(corner_top_left_i, corner_bottom_left_i, threshold_q);
  end

  // Stage valid
  always_comb begin
    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_cell_q <= fr_cell_d;
    end
  end

endmodule

FILE: design/msct_back.sv
// Back end: walks the four triangle slots of the queue head and drives the result register.
// Depends on msct_pkg for the triangle table and the cell record.
module msct_back #(
  parameter int GRID_WIDTH  = msct_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = msct_pkg::GRID_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msct_pkg::cell_t                    head_i,
  input  msct_pkg::q_status_t                q_status_i,
  output logic                               pop_o,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [msct_pkg::VTX_W-1:0]         vertex_a_o,
  output logic [msct_pkg::VTX_W-1:0]         vertex_b_o,
  output logic [msct_pkg::VTX_W-1:0]         vertex_c_o,
  output logic [msct_pkg::SLOT_W-1:0]        slot_number_o,
  output logic [msct_pkg::COUNT_W-1:0]       triangle_count_o,
  output logic [msct_pkg::CODE_W-1:0]        case_code_o,
  output logic [msct_pkg::FRAC_W-1:0]        top_fraction_o,
  output logic [msct_pkg::FRAC_W-1:0]        left_fraction_o,
  output logic                               last_slot_o
);

  localparam int HBASE = GRID_WIDTH * GRID_HEIGHT;
  localparam int VBASE = HBASE + (GRID_WIDTH - 1) * GRID_HEIGHT;
  localparam logic [msct_pkg::VTX_W-1:0] W_V     = msct_pkg::VTX_W'(GRID_WIDTH);
  localparam logic [msct_pkg::VTX_W-1:0] W1_V    = msct_pkg::VTX_W'(GRID_WIDTH - 1);
  localparam logic [msct_pkg::VTX_W-1:0] HBASE_V = msct_pkg::VTX_W'(HBASE);
  localparam logic [msct_pkg::VTX_W-1:0] VBASE_V = msct_pkg::VTX_W'(VBASE);
  localparam logic [msct_pkg::VTX_W-1:0] ONE_V   = msct_pkg::VTX_W'(1);

  logic [msct_pkg::SLOT_W-1:0]          slot_q, slot_d;
  logic                                 out_valid_q, out_valid_d;
  logic                                 load;
  logic                                 slot_used;
  logic [msct_pkg::VTX_W-1:0]           x_ext;
  logic [7:0][msct_pkg::VTX_W-1:0]      vtx;
  msct_pkg::tri_row_t                   row;
  msct_pkg::tri_t                       tri_sel;

  // Load the result register whenever the queue holds a cell and the register is empty or being taken
  assign load    = !q_status_i.empty && (!out_valid_q || !stall_i);
  assign pop_o   = load && (slot_q == msct_pkg::LAST_SLOT);
  assign valid_o = out_valid_q;

  // Lattice indices of the eight cell vertices (mod 2^18)
  assign x_ext  = {{(msct_pkg::VTX_W - msct_pkg::COORD_W){1'b0}}, head_i.x};
  assign vtx[0] = x_ext + head_i.y_w;
  assign vtx[1] = x_ext + ONE_V + head_i.y_w;
  assign vtx[2] = x_ext + ONE_V + head_i.y_w + W_V;
  assign vtx[3] = x_ext + head_i.y_w + W_V;
  assign vtx[4] = HBASE_V + x_ext + head_i.y_w1;
  assign vtx[5] = HBASE_V + x_ext + head_i.y_w1 + W1_V;
  assign vtx[6] = VBASE_V + x_ext + head_i.y_w;
  assign vtx[7] = VBASE_V + x_ext + ONE_V + head_i.y_w;

  // Triangle of the current slot
  assign row       = msct_pkg::tri_lookup(head_i.code);
  assign tri_sel   = row[slot_q];
  assign slot_used = ({1'b0, slot_q} < head_i.count);

  // Slot counter and result valid
  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (load) begin
      slot_d      = slot_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      vertex_a_o       <= slot_used ? vtx[tri_sel.a] : '0;
      vertex_b_o       <= slot_used ? vtx[tri_sel.b] : '0;
      vertex_c_o       <= slot_used ? vtx[tri_sel.c] : '0;
      slot_number_o    <= slot_q;
      triangle_count_o <= head_i.count;
      case_code_o      <= head_i.code;
      top_fraction_o   <= head_i.top;
      left_fraction_o  <= head_i.left;
      last_slot_o      <= (slot_q == msct_pkg::LAST_SLOT);
    end
  end

endmodule

FILE: design/marching_squares_cell_triangulator_core.sv
// Top level of the marching-squares cell triangulator: front, cell queue and back.
// Depends on msct_pkg, msct_front, msct_queue and msct_back.
//
//   channel   handshake               payload
//   input     valid_i / stall_o       cell_x_i, cell_y_i, corner_*_i
//   output    valid_o / stall_i       vertex_a/b/c_o, slot_number_o, triangle_count_o,
//                                     case_code_o, top_fraction_o, left_fraction_o,
//                                     last_slot_o
//   config    threshold_we_i          threshold_i
//
// Each cell gives four results, one per cycle from the back's slot counter while
// stall_i is low; the slot walk limits the sustained cell rate.
// The front holds one cell and the queue two more; the front stalls only when
// both are full. Reset clears all valid and pointer state, threshold goes to 128.
module marching_squares_cell_triangulator_core #(
  parameter int GRID_WIDTH  = msct_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = msct_pkg::GRID_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               threshold_we_i,
  input  logic [msct_pkg::DENS_W-1:0]        threshold_i,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [msct_pkg::COORD_W-1:0]       cell_x_i,
  input  logic [msct_pkg::COORD_W-1:0]       cell_y_i,
  input  logic [msct_pkg::DENS_W-1:0]        corner_top_left_i,
  input  logic [msct_pkg::DENS_W-1:0]        corner_top_right_i,
  input  logic [msct_pkg::DENS_W-1:0]        corner_bottom_right_i,
  input  logic [msct_pkg::DENS_W-1:0]        corner_bottom_left_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [msct_pkg::VTX_W-1:0]         vertex_a_o,
  output logic [msct_pkg::VTX_W-1:0]         vertex_b_o,
  output logic [msct_pkg::VTX_W-1:0]         vertex_c_o,
  output logic [msct_pkg::SLOT_W-1:0]        slot_number_o,
  output logic [msct_pkg::COUNT_W-1:0]       triangle_count_o,
  output logic [msct_pkg::CODE_W-1:0]        case_code_o,
  output logic [msct_pkg::FRAC_W-1:0]        top_fraction_o,
  output logic [msct_pkg::FRAC_W-1:0]        left_fraction_o,
  output logic                               last_slot_o
);

  logic                 push, pop;
  msct_pkg::cell_t      push_cell, head_cell;
  msct_pkg::q_status_t  q_status;

  // Intake and classification
  msct_front #(
    .GRID_WIDTH (GRID_WIDTH)
  ) u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .threshold_we_i        (threshold_we_i),
    .threshold_i           (threshold_i),
    .valid_i               (valid_i),
    .stall_o               (stall_o),
    .cell_x_i              (cell_x_i),
    .cell_y_i              (cell_y_i),
    .corner_top_left_i     (corner_top_left_i),
    .corner_top_right_i    (corner_top_right_i),
    .corner_bottom_right_i (corner_bottom_right_i),
    .corner_bottom_left_i  (corner_bottom_left_i),
    .q_status_i            (q_status),
    .push_o                (push),
    .cell_o                (push_cell)
  );

  // Decoupling queue
  msct_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cell),
    .pop_i       (pop),
    .head_o      (head_cell),
    .status_o    (q_status)
  );

  // Slot emission
  msct_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_cell),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .vertex_a_o       (vertex_a_o),
    .vertex_b_o       (vertex_b_o),
    .vertex_c_o       (vertex_c_o),
    .slot_number_o    (slot_number_o),
    .triangle_count_o (triangle_count_o),
    .case_code_o      (case_code_o),
    .top_fraction_o   (top_fraction_o),
    .left_fraction_o  (left_fraction_o),
    .last_slot_o      (last_slot_o)
  );

endmodule

FILE: design/msct_checker.sv
// Port-level checks on the triangulator's result channel, bound to the top level.
// Depends on msct_pkg and marching_squares_cell_triangulator_core.
module msct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_o,
  input logic                          stall_i,
  input logic [msct_pkg::VTX_W-1:0]    vertex_a_o,
  input logic [msct_pkg::VTX_W-1:0]    vertex_b_o,
  input logic [msct_pkg::VTX_W-1:0]    vertex_c_o,
  input logic [msct_pkg::SLOT_W-1:0]   slot_number_o,
  input logic [msct_pkg::COUNT_W-1:0]  triangle_count_o,
  input logic [msct_pkg::FRAC_W-1:0]   top_fraction_o,
  input logic [msct_pkg::FRAC_W-1:0]   left_fraction_o,
  input logic                          last_slot_o
);

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result dropped while stalled");

  // Slots of one cell follow each other without a gap
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_slot_o |=>
      valid_o && (slot_number_o == $past(slot_number_o) + 2'd1))
    else $error("slot sequence broken");

  // Last-slot flag matches the slot number
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_slot_o == (slot_number_o == msct_pkg::LAST_SLOT)))
    else $error("last_slot flag mismatch");

  // Slots past the triangle count carry zero indices
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ({1'b0, slot_number_o} >= triangle_count_o) |->
      (vertex_a_o == '0) && (vertex_b_o == '0) && (vertex_c_o == '0))
    else $error("unused slot carries vertices");

  // Fractions stay inside the clamp window
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (top_fraction_o >= msct_pkg::FRAC_LOW) &&
                (top_fraction_o <= msct_pkg::FRAC_HIGH) &&
                (left_fraction_o >= msct_pkg::FRAC_LOW) &&
                (left_fraction_o <= msct_pkg::FRAC_HIGH))
    else $error("fraction outside clamp range");

endmodule

bind marching_squares_cell_triangulator_core msct_checker u_msct_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_o          (valid_o),
  .stall_i          (stall_i),
  .vertex_a_o       (vertex_a_o),
  .vertex_b_o       (vertex_b_o),
  .vertex_c_o       (vertex_c_o),
  .slot_number_o    (slot_number_o),
  .triangle_count_o (triangle_count_o),
  .top_fraction_o   (top_fraction_o),
  .left_fraction_o  (left_fraction_o),
  .last_slot_o      (last_slot_o)
);
